FILE: src/cpio_binary_archive_parser_assert.svh
// assertion macros shared by the cpio archive parser rtl
`ifndef CPIO_BINARY_ARCHIVE_PARSER_ASSERT_SVH
`define CPIO_BINARY_ARCHIVE_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBAP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbap check failed");

// next-cycle implication, checked out of reset
`define CBAP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbap check failed");

`endif

FILE: src/cbap_pkg.sv
// types, codes and constants of the cpio archive parser
`default_nettype none
package cbap_pkg;

	typedef enum logic [7:0] {
		PH_MAGIC0  = 8'b0000_0001,
		PH_MAGIC1  = 8'b0000_0010,
		PH_HEADER  = 8'b0000_0100,
		PH_NAME    = 8'b0000_1000,
		PH_NAMEPAD = 8'b0001_0000,
		PH_DATA    = 8'b0010_0000,
		PH_DATAPAD = 8'b0100_0000,
		PH_HALT    = 8'b1000_0000
	} cbap_phase_t;

	localparam logic [2:0] KIND_NAME      = 3'd0;
	localparam logic [2:0] KIND_RECORD    = 3'd1;
	localparam logic [2:0] KIND_END       = 3'd2;
	localparam logic [2:0] KIND_MAGIC_ERR = 3'd3;
	localparam logic [2:0] KIND_ASCII     = 3'd4;
	localparam logic [2:0] KIND_INVALID   = 3'd5;

	localparam logic [7:0] MAGIC_HI     = 8'h71;
	localparam logic [7:0] MAGIC_LO     = 8'hC7;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;

	// header byte positions (counted from the magic): HPOS_FIRST opens the header, the rest close a 16-bit half
	localparam logic [4:0] HPOS_FIRST    = 5'd2;
	localparam logic [4:0] HPOS_MODE     = 5'd7;
	localparam logic [4:0] HPOS_MTIME_HI = 5'd17;
	localparam logic [4:0] HPOS_MTIME_LO = 5'd19;
	localparam logic [4:0] HPOS_NAMESIZE = 5'd21;
	localparam logic [4:0] HPOS_FSIZE_HI = 5'd23;
	localparam logic [4:0] HPOS_FSIZE_LO = 5'd25;

	localparam logic [15:0] TRAILER_LEN  = 16'd11;
	localparam logic [15:0] TRAILER_CHARS = 16'd10;

	typedef struct packed {
		cbap_phase_t  phase;
		logic [31:0]  byte_count;
		logic         order_big;
		logic [7:0]   low_hold;
		logic [15:0]  accum_hi;
		logic [15:0]  name_size;
		logic [31:0]  file_size;
		logic [15:0]  mode;
		logic [31:0]  mtime;
		logic [31:0]  offset;
		logic         trailer_match;
	} cbap_state_t;

	// parser state straight out of reset
	localparam cbap_state_t CBAP_STATE_RESET = '{
		phase:         PH_MAGIC0,
		byte_count:    32'd0,
		order_big:     1'b0,
		low_hold:      8'd0,
		accum_hi:      16'd0,
		name_size:     16'd0,
		file_size:     32'd0,
		mode:          16'd0,
		mtime:         32'd0,
		offset:        32'd0,
		trailer_match: 1'b1
	};

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  name_char;
		logic [15:0] name_size;
		logic [31:0] file_size;
		logic [31:0] data_offset;
		logic [15:0] file_mode;
		logic [31:0] mod_time;
		logic        big_endian_hdr;
	} cbap_res_t;

	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h54; // T
			4'd1: c = 8'h52; // R
			4'd2: c = 8'h41; // A
			4'd3: c = 8'h49; // I
			4'd4: c = 8'h4C; // L
			4'd5: c = 8'h45; // E
			4'd6: c = 8'h52; // R
			4'd7: c = 8'h21; // !
			4'd8: c = 8'h21;
			4'd9: c = 8'h21;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/cbap_if.sv
// valid/ready channel interfaces for archive bytes and parse results
`default_nettype none
interface cbap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface cbap_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  name_char;
	logic [15:0] name_size;
	logic [31:0] file_size;
	logic [31:0] data_offset;
	logic [15:0] file_mode;
	logic [31:0] mod_time;
	logic        big_endian_hdr;

	modport source (output valid, output kind, output name_char, output name_size,
		output file_size, output data_offset, output file_mode, output mod_time,
		output big_endian_hdr, input ready);
	modport sink (input valid, input kind, input name_char, input name_size,
		input file_size, input data_offset, input file_mode, input mod_time,
		input big_endian_hdr, output ready);
endinterface
`default_nettype wire

FILE: src/cbap_step.sv
// next-state and result logic for one archive byte
`default_nettype none
module cbap_step
	import cbap_pkg::*;
(
	input  var cbap_state_t st,
	input  var logic [7:0]  byte_in,
	output cbap_state_t     nxt,
	output logic            res_valid,
	output cbap_res_t       res
);

	logic [4:0]  pos;
	logic [15:0] half;
	logic [15:0] ncnt;
	logic [31:0] dcnt;
	logic        do_finish;
	logic        is_trailer;

	assign pos  = st.byte_count[4:0];
	assign ncnt = st.byte_count[15:0];
	assign dcnt = st.byte_count - 32'd1;
	assign half = st.order_big ? {st.low_hold, byte_in} : {byte_in, st.low_hold};

	always_comb begin
		nxt        = st;
		res_valid  = 1'b0;
		res        = '0;
		do_finish  = 1'b0;
		is_trailer = 1'b0;

		if (st.phase != PH_HALT && st.offset != 32'hFFFF_FFFF) begin
			nxt.offset = st.offset + 32'd1;
		end

		case (st.phase)
			PH_MAGIC0: begin
				if (byte_in == MAGIC_HI) begin
					nxt.order_big = 1'b1;
					nxt.phase     = PH_MAGIC1;
				end else if (byte_in == MAGIC_LO) begin
					nxt.order_big = 1'b0;
					nxt.phase     = PH_MAGIC1;
				end else begin
					res_valid = 1'b1;
					res.kind  = (byte_in == ASCII_ZERO) ? KIND_ASCII : KIND_INVALID;
					nxt.phase = PH_HALT;
				end
			end
			PH_MAGIC1: begin
				if (byte_in != (st.order_big ? MAGIC_LO : MAGIC_HI)) begin
					res_valid = 1'b1;
					res.kind  = KIND_MAGIC_ERR;
					nxt.phase = PH_HALT;
				end else begin
					nxt.byte_count = {27'd0, HPOS_FIRST};
					nxt.phase      = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (!pos[0]) begin
					nxt.low_hold = byte_in;
				end else begin
					case (pos)
						HPOS_MODE:     nxt.mode = half;
						HPOS_MTIME_HI: nxt.accum_hi = half;
						HPOS_MTIME_LO: nxt.mtime = {st.accum_hi, half};
						HPOS_NAMESIZE: nxt.name_size = half;
						HPOS_FSIZE_HI: nxt.accum_hi = half;
						HPOS_FSIZE_LO: nxt.file_size = {st.accum_hi, half};
						default: ;
					endcase
				end
				if (pos == HPOS_FSIZE_LO) begin
					nxt.byte_count    = '0;
					nxt.trailer_match = 1'b1;
					if (nxt.name_size == 16'd0) begin
						do_finish = 1'b1;
					end else begin
						nxt.phase = PH_NAME;
					end
				end else begin
					nxt.byte_count = {27'd0, pos + 5'd1};
				end
			end
			PH_NAME: begin
				if ({1'b0, ncnt} + 17'd1 < {1'b0, st.name_size}) begin
					if (ncnt >= TRAILER_CHARS || trailer_char(ncnt[3:0]) != byte_in) begin
						nxt.trailer_match = 1'b0;
					end
					nxt.byte_count = {16'd0, ncnt + 16'd1};
					res_valid      = 1'b1;
					res.kind       = KIND_NAME;
					res.name_char  = byte_in;
				end else if (st.name_size[0]) begin
					nxt.phase = PH_NAMEPAD;
				end else begin
					do_finish = 1'b1;
				end
			end
			PH_NAMEPAD: do_finish = 1'b1;
			PH_DATA: begin
				nxt.byte_count = dcnt;
				if (dcnt == 32'd0) begin
					nxt.phase = st.file_size[0] ? PH_DATAPAD : PH_MAGIC0;
				end
			end
			PH_DATAPAD: nxt.phase = PH_MAGIC0;
			default: nxt.phase = PH_HALT;
		endcase

		// descriptor from the (possibly just written) header fields
		if (do_finish) begin
			is_trailer         = nxt.trailer_match && (nxt.name_size == TRAILER_LEN);
			res_valid          = 1'b1;
			res.kind           = is_trailer ? KIND_END : KIND_RECORD;
			res.name_size      = nxt.name_size;
			res.file_size      = nxt.file_size;
			res.data_offset    = nxt.offset;
			res.file_mode      = nxt.mode;
			res.mod_time       = nxt.mtime;
			res.big_endian_hdr = nxt.order_big;
			if (is_trailer) begin
				nxt.phase = PH_HALT;
			end else if (nxt.file_size == 32'd0) begin
				nxt.phase = PH_MAGIC0;
			end else begin
				nxt.byte_count = nxt.file_size;
				nxt.phase      = PH_DATA;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/cpio_binary_archive_parser.sv
// latency: a result beat is valid the cycle after the byte beat that causes it
// throughput: one archive byte per cycle while the result register is free or draining
// the only stall is a held result register with result.ready low
// reset (arst_n low, asynchronous): parser waits for the first magic byte,
// offset and header fields clear, no result pending
`default_nettype none
`include "cpio_binary_archive_parser_assert.svh"
module cpio_binary_archive_parser
	import cbap_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	cbap_byte_if.sink   stream,
	cbap_res_if.source  result
);

	cbap_state_t state_q;
	cbap_state_t state_nxt;
	cbap_res_t   res_q;
	cbap_res_t   step_res;
	logic        step_valid;
	logic        res_valid_q;
	logic        accept;

	// a byte goes in whenever the result slot is free or being emptied
	assign stream.ready = !res_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	// whole per-byte parse: phase sequencing, header assembly, trailer test
	cbap_step u_step (
		.st        (state_q),
		.byte_in   (stream.byte_in),
		.nxt       (state_nxt),
		.res_valid (step_valid),
		.res       (step_res)
	);

	// parser state, advanced once per accepted byte beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CBAP_STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result register; a new result only lands when the old one is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= step_valid;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step_valid) begin
			res_q <= step_res;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.kind           = res_q.kind;
	assign result.name_char      = res_q.name_char;
	assign result.name_size      = res_q.name_size;
	assign result.file_size      = res_q.file_size;
	assign result.data_offset    = res_q.data_offset;
	assign result.file_mode      = res_q.file_mode;
	assign result.mod_time       = res_q.mod_time;
	assign result.big_endian_hdr = res_q.big_endian_hdr;

	// once halted the parser never leaves the halt phase
	`CBAP_ASSERT_NXT(a_halt_sticks, state_q.phase == PH_HALT, state_q.phase == PH_HALT)
	// a pending error or trailer end always goes with a halted parser
	`CBAP_ASSERT_IMP(a_stop_halts, res_valid_q && (res_q.kind == KIND_END ||
		res_q.kind == KIND_MAGIC_ERR || res_q.kind == KIND_ASCII ||
		res_q.kind == KIND_INVALID), state_q.phase == PH_HALT)
	// the offset sticks once saturated
	`CBAP_ASSERT_NXT(a_offset_sat, state_q.offset == 32'hFFFF_FFFF,
		state_q.offset == 32'hFFFF_FFFF)
	// input stalls only behind a held result
	`CBAP_ASSERT_IMP(a_stall_cause, !stream.ready, res_valid_q && !result.ready)

endmodule
`default_nettype wire
